[sv/arm_inverse_kinematics_to_steps_top_macros.svh]
// Assertion macros for the arm IK block.
// AIK_ASSERT_IMP: same-cycle implication. AIK_ASSERT_NXT: next-cycle implication.
`ifndef ARM_INVERSE_KINEMATICS_TO_STEPS_TOP_MACROS_SVH
`define ARM_INVERSE_KINEMATICS_TO_STEPS_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define AIK_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("arm ik check failed");
`define AIK_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("arm ik check failed");
`else
`define AIK_ASSERT_IMP(name, clk, rst, ante, cons)
`define AIK_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

[sv/aiks_pkg.sv]
`default_nettype none
package aiks_pkg;

   localparam int CORDIC_ITERATIONS = 16;

   localparam int COORD_W    = 18;
   localparam int LINK_W     = 10;
   localparam int SCALE_W    = 24;
   localparam int STEP_W     = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 24;

   // squared distances and root extraction
   localparam int SQR_W      = 2 * COORD_W - 1;   // one square, always >= 0
   localparam int SUM_W      = SQR_W + 1;         // sum of three squares
   localparam int LSQ_W      = 2 * LINK_W;
   localparam int D2_SH      = 18;                // (512)^2 = 2^18
   localparam int SQ_W       = LSQ_W + D2_SH;     // radicand width
   localparam int ROOT_W     = SQ_W / 2;
   localparam int ISQRT_LAT  = ROOT_W + 1;

   // CORDIC
   localparam int CIN_W       = ROOT_W + 1;
   localparam int CX_W        = 36;
   localparam int CZ_W        = 20;
   localparam int PRESCALE_SH = 12;
   localparam int CORDIC_LAT  = CORDIC_ITERATIONS + 1;

   // angles in Q13, step conversion
   localparam int ANG_W    = 18;
   localparam int MAG_W    = ANG_W - 1;
   localparam int PROD_W   = MAG_W + SCALE_W;
   localparam int STEP_SH  = 29;

   localparam logic signed [CZ_W-1:0]  PI_Q16         = 20'sd205887;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q13    = 18'sd12868;
   localparam logic signed [ANG_W-1:0] QUARTER_PI_Q13 = 18'sd6434;
   localparam logic signed [ANG_W-1:0] THIRD_PI_Q13   = 18'sd8579;
   localparam logic signed [ANG_W-1:0] SIXTH_PI_Q13   = 18'sd4289;

   localparam logic [CSR_IDX_W-1:0] CSR_LINK_LENGTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SCALE  = 1'd1;

   localparam logic [LINK_W-1:0]  LINK_RESET  = 10'd120;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd327098;

   typedef struct packed {
      logic rev;
      logic unreach;
      logic sxy_nz;
      logic s2_nz;
   } flags_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      flags_type                 flags;
   } side_type;

   // atan(2^-i) in Q16 radians
   function automatic logic signed [CZ_W-1:0] atan_q16(input int i);
      logic signed [CZ_W-1:0] v;
      unique case (i)
         0:       v = 20'sd51472;
         1:       v = 20'sd30386;
         2:       v = 20'sd16055;
         3:       v = 20'sd8150;
         4:       v = 20'sd4091;
         5:       v = 20'sd2047;
         6:       v = 20'sd1024;
         7:       v = 20'sd512;
         8:       v = 20'sd256;
         9:       v = 20'sd128;
         10:      v = 20'sd64;
         11:      v = 20'sd32;
         12:      v = 20'sd16;
         13:      v = 20'sd8;
         14:      v = 20'sd4;
         15:      v = 20'sd2;
         16:      v = 20'sd1;
         default: v = 20'sd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

[sv/arm_inverse_kinematics_to_steps_top.sv]
// Two-link arm inverse kinematics to motor step counts. Each req word carries a target
// point (x, y, z, signed Q8 mm) and a reverse bit; each rsp word carries signed 16-bit
// step counts for shoulder, base and elbow, a direction-update flag per joint, the
// direction-pin level (NOT reverse) and an unreachable flag (steps and updates forced to
// zero). The block is a fixed pipeline that takes one word every cycle unless frozen:
// squaring and range check, bit-per-stage square root, CORDIC atan2 (one iteration per
// stage), then folding and step scaling. The whole pipeline advances together; it
// freezes only while a finished rsp word is held and rsp_ready is low, and req_ready
// follows that condition. link_length and step_scale must be written through the csr
// port only while the block is idle; the block itself does not enforce it.
`default_nettype none
`include "arm_inverse_kinematics_to_steps_top_macros.svh"
module arm_inverse_kinematics_to_steps_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [aiks_pkg::COORD_W-1:0]  req_target_x,
   input  logic signed [aiks_pkg::COORD_W-1:0]  req_target_y,
   input  logic signed [aiks_pkg::COORD_W-1:0]  req_target_z,
   input  logic                                 req_reverse,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [aiks_pkg::STEP_W-1:0]   rsp_shoulder_steps,
   output logic signed [aiks_pkg::STEP_W-1:0]   rsp_base_steps,
   output logic signed [aiks_pkg::STEP_W-1:0]   rsp_elbow_steps,
   output logic                                 rsp_shoulder_dir_update,
   output logic                                 rsp_base_dir_update,
   output logic                                 rsp_elbow_dir_update,
   output logic                                 rsp_dir_level,
   output logic                                 rsp_unreachable,
   input  logic                                 csr_we,
   input  logic [aiks_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [aiks_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import aiks_pkg::*;

   localparam int MID_LAT = ISQRT_LAT + CORDIC_LAT;

   // ---------------------------------------------------------------- csr
   logic [LINK_W-1:0]  link_length_ff;
   logic [SCALE_W-1:0] step_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_length_ff <= LINK_RESET;
         step_scale_ff  <= SCALE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LINK_LENGTH: link_length_ff <= csr_wdata[LINK_W-1:0];
            CSR_STEP_SCALE:  step_scale_ff  <= csr_wdata[SCALE_W-1:0];
         endcase
      end
   end

   // ---------------------------------------------------------------- flow control
   // Single advance enable for every stage: move unless the held rsp word is blocked.
   logic rsp_valid_ff;
   logic en;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // ---------------------------------------------------------------- S1: squares
   logic signed [2*COORD_W-1:0] x_sq;
   logic signed [2*COORD_W-1:0] y_sq;
   logic signed [2*COORD_W-1:0] z_sq;
   logic [LSQ_W-1:0]            lsq;

   assign x_sq = req_target_x * req_target_x;
   assign y_sq = req_target_y * req_target_y;
   assign z_sq = req_target_z * req_target_z;
   assign lsq  = link_length_ff * link_length_ff;

   logic             v1_ff;
   logic [SQR_W-1:0] xx_ff;
   logic [SQR_W-1:0] yy_ff;
   logic [SQR_W-1:0] zz_ff;
   logic [LSQ_W-1:0] lsq_ff;
   side_type         side1_ff;
   side_type         side1_in;

   always_comb begin
      side1_in               = '0;
      side1_in.x             = req_target_x;
      side1_in.y             = req_target_y;
      side1_in.z             = req_target_z;
      side1_in.flags.rev     = req_reverse;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xx_ff    <= x_sq[SQR_W-1:0];
         yy_ff    <= y_sq[SQR_W-1:0];
         zz_ff    <= z_sq[SQR_W-1:0];
         lsq_ff   <= lsq;
         side1_ff <= side1_in;
      end
   end

   // ---------------------------------------------------------------- S2: sums, reach
   logic [SUM_W-1:0] sxy_in;
   logic [SUM_W-1:0] s2_in;
   logic [SQ_W-1:0]  d2;
   logic [SQ_W-1:0]  s2_ext;
   side_type         side2_in;

   always_comb begin
      sxy_in   = {1'b0, xx_ff} + {1'b0, yy_ff};
      s2_in    = sxy_in + {1'b0, zz_ff};
      d2       = {lsq_ff, {D2_SH{1'b0}}};
      s2_ext   = {{(SQ_W-SUM_W){1'b0}}, s2_in};
      side2_in = side1_ff;
      side2_in.flags.unreach = (s2_ext > d2);
      side2_in.flags.sxy_nz  = (sxy_in != '0);
      side2_in.flags.s2_nz   = (s2_in != '0);
   end

   logic             v2_ff;
   logic [SUM_W-1:0] sxy_ff;
   logic [SUM_W-1:0] s2_ff;
   logic [SQ_W-1:0]  diff_ff;
   side_type         side2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   // diff wraps when out of reach; that result is discarded downstream
   always_ff @(posedge clock) begin
      if (en) begin
         sxy_ff   <= sxy_in;
         s2_ff    <= s2_in;
         diff_ff  <= d2 - s2_ext;
         side2_ff <= side2_in;
      end
   end

   // ---------------------------------------------------------------- square roots
   logic [ROOT_W-1:0] rrot;
   logic [ROOT_W-1:0] rside;
   logic [ROOT_W-1:0] rdiff;

   aiks_isqrt u_sqrt_xy (
      .clock    (clock),
      .en       (en),
      .radicand ({{(SQ_W-SUM_W){1'b0}}, sxy_ff}),
      .root     (rrot)
   );

   aiks_isqrt u_sqrt_s2 (
      .clock    (clock),
      .en       (en),
      .radicand ({{(SQ_W-SUM_W){1'b0}}, s2_ff}),
      .root     (rside)
   );

   aiks_isqrt u_sqrt_diff (
      .clock    (clock),
      .en       (en),
      .radicand (diff_ff),
      .root     (rdiff)
   );

   // coordinates and flags ride alongside the root pipeline
   side_type  side_ff [0:ISQRT_LAT-1];
   flags_type flg_ff  [0:CORDIC_LAT-1];
   logic      mid_vld_ff [0:MID_LAT-1];

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side2_ff;
         for (int k = 1; k < ISQRT_LAT; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
         flg_ff[0] <= side_ff[ISQRT_LAT-1].flags;
         for (int k = 1; k < CORDIC_LAT; k++) begin
            flg_ff[k] <= flg_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MID_LAT; k++) begin
            mid_vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         mid_vld_ff[0] <= v2_ff;
         for (int k = 1; k < MID_LAT; k++) begin
            mid_vld_ff[k] <= mid_vld_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------- CORDIC x3
   side_type               side_q;
   logic signed [CZ_W-1:0] ang_rot;
   logic signed [CZ_W-1:0] ang_half;
   logic signed [CZ_W-1:0] ang_low;

   assign side_q = side_ff[ISQRT_LAT-1];

   aiks_cordic u_cordic_rot (
      .clock (clock),
      .en    (en),
      .y_in  ({{(CIN_W-COORD_W){side_q.y[COORD_W-1]}}, side_q.y}),
      .x_in  ({{(CIN_W-COORD_W){side_q.x[COORD_W-1]}}, side_q.x}),
      .angle (ang_rot)
   );

   aiks_cordic u_cordic_half (
      .clock (clock),
      .en    (en),
      .y_in  ({1'b0, rside}),
      .x_in  ({1'b0, rdiff}),
      .angle (ang_half)
   );

   aiks_cordic u_cordic_low (
      .clock (clock),
      .en    (en),
      .y_in  ({{(CIN_W-COORD_W){side_q.z[COORD_W-1]}}, side_q.z}),
      .x_in  ({1'b0, rrot}),
      .angle (ang_low)
   );

   // ---------------------------------------------------------------- angle helpers
   // Q16 -> Q13, round half up
   function automatic logic signed [ANG_W-1:0] to_q13(input logic signed [CZ_W-1:0] z);
      logic signed [CZ_W-1:0] t;
      t = z + 20'sd4;
      return ANG_W'(t >>> 3);
   endfunction

   // ((a + off) rem m) - off, rem truncating toward zero; |a + off| < 8m
   function automatic logic signed [ANG_W-1:0] fold(input logic signed [ANG_W-1:0] a,
                                                     input logic signed [ANG_W-1:0] m,
                                                     input logic signed [ANG_W-1:0] off);
      logic signed [ANG_W-1:0] t;
      logic [ANG_W-1:0]        mag;
      logic [ANG_W-1:0]        mu;
      logic                    neg;
      logic signed [ANG_W-1:0] r;
      t   = a + off;
      neg = t[ANG_W-1];
      mag = neg ? ANG_W'(-t) : ANG_W'(t);
      mu  = ANG_W'(m);
      if (mag >= (mu << 2)) mag = mag - (mu << 2);
      if (mag >= (mu << 1)) mag = mag - (mu << 1);
      if (mag >= mu)        mag = mag - mu;
      r = neg ? -signed'(mag) : signed'(mag);
      return r - off;
   endfunction

   function automatic logic out_of(input logic signed [ANG_W-1:0] a,
                                   input logic signed [ANG_W-1:0] lim);
      return (a > lim) || (a < -lim);
   endfunction

   // ---------------------------------------------------------------- P1: round, low
   logic                    v_p1_ff;
   flags_type               flg_p1_ff;
   logic signed [ANG_W-1:0] rot_p1_ff;
   logic signed [ANG_W-1:0] half_p1_ff;
   logic signed [ANG_W-1:0] low_p1_ff;
   flags_type               flg_c;
   logic signed [ANG_W-1:0] half_c;

   assign flg_c  = flg_ff[CORDIC_LAT-1];
   assign half_c = to_q13(ang_half);

   always_ff @(posedge clock) begin
      if (en) begin
         flg_p1_ff  <= flg_c;
         half_p1_ff <= half_c;
         rot_p1_ff  <= flg_c.sxy_nz ? to_q13(ang_rot) : '0;
         low_p1_ff  <= flg_c.s2_nz ? (to_q13(ang_low) - half_c) : '0;
      end
   end

   // ---------------------------------------------------------------- P2: fold rot, low
   logic                    v_p2_ff;
   flags_type               flg_p2_ff;
   logic signed [ANG_W-1:0] rot_f_ff;
   logic signed [ANG_W-1:0] low_f_ff;
   logic signed [ANG_W-1:0] half_p2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         flg_p2_ff  <= flg_p1_ff;
         half_p2_ff <= half_p1_ff;
         rot_f_ff   <= out_of(rot_p1_ff, HALF_PI_Q13) ?
                       fold(rot_p1_ff, HALF_PI_Q13, QUARTER_PI_Q13) : rot_p1_ff;
         low_f_ff   <= out_of(low_p1_ff, QUARTER_PI_Q13) ?
                       fold(low_p1_ff, HALF_PI_Q13, QUARTER_PI_Q13) : low_p1_ff;
      end
   end

   // ---------------------------------------------------------------- P3: elbow sum
   logic                    v_p3_ff;
   flags_type               flg_p3_ff;
   logic signed [ANG_W-1:0] rot_p3_ff;
   logic signed [ANG_W-1:0] low_p3_ff;
   logic signed [ANG_W-1:0] high_p3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         flg_p3_ff  <= flg_p2_ff;
         rot_p3_ff  <= rot_f_ff;
         low_p3_ff  <= low_f_ff;
         high_p3_ff <= (half_p2_ff <<< 1) + low_f_ff;
      end
   end

   // ---------------------------------------------------------------- P4: fold elbow
   logic                    v_p4_ff;
   flags_type               flg_p4_ff;
   logic signed [ANG_W-1:0] rot_p4_ff;
   logic signed [ANG_W-1:0] low_p4_ff;
   logic signed [ANG_W-1:0] high_f_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         flg_p4_ff <= flg_p3_ff;
         rot_p4_ff <= rot_p3_ff;
         low_p4_ff <= low_p3_ff;
         high_f_ff <= out_of(high_p3_ff, THIRD_PI_Q13) ?
                      fold(high_p3_ff, THIRD_PI_Q13, SIXTH_PI_Q13) : high_p3_ff;
      end
   end

   // ---------------------------------------------------------------- P5: scale
   function automatic logic [MAG_W-1:0] mag_of(input logic signed [ANG_W-1:0] a);
      logic signed [ANG_W-1:0] t;
      t = a[ANG_W-1] ? -a : a;
      return t[MAG_W-1:0];
   endfunction

   logic              v_p5_ff;
   flags_type         flg_p5_ff;
   logic [PROD_W-1:0] prod_sh_ff;
   logic [PROD_W-1:0] prod_rot_ff;
   logic [PROD_W-1:0] prod_el_ff;
   logic [2:0]        neg_ff;   // shoulder, base, elbow
   logic [2:0]        nz_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         flg_p5_ff   <= flg_p4_ff;
         prod_sh_ff  <= mag_of(low_p4_ff) * step_scale_ff;
         prod_rot_ff <= mag_of(rot_p4_ff) * step_scale_ff;
         prod_el_ff  <= mag_of(high_f_ff) * step_scale_ff;
         neg_ff      <= {low_p4_ff[ANG_W-1], rot_p4_ff[ANG_W-1], high_f_ff[ANG_W-1]};
         nz_ff       <= {low_p4_ff != '0, rot_p4_ff != '0, high_f_ff != '0};
      end
   end

   // ---------------------------------------------------------------- P6: saturate, rsp
   function automatic logic [STEP_W-1:0] sat_steps(input logic [PROD_W-1:0] p,
                                                   input logic neg);
      logic [STEP_W:0] m;
      m = (STEP_W+1)'(p >> STEP_SH);
      if (neg) begin
         return (m > {1'b0, 1'b1, {(STEP_W-1){1'b0}}}) ? {1'b1, {(STEP_W-1){1'b0}}} :
                STEP_W'(-m);
      end
      return (m > {2'b00, {(STEP_W-1){1'b1}}}) ? {1'b0, {(STEP_W-1){1'b1}}} :
             m[STEP_W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         v_p1_ff      <= 1'b0;
         v_p2_ff      <= 1'b0;
         v_p3_ff      <= 1'b0;
         v_p4_ff      <= 1'b0;
         v_p5_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v_p1_ff      <= mid_vld_ff[MID_LAT-1];
         v_p2_ff      <= v_p1_ff;
         v_p3_ff      <= v_p2_ff;
         v_p4_ff      <= v_p3_ff;
         v_p5_ff      <= v_p4_ff;
         rsp_valid_ff <= v_p5_ff;
      end
   end

   logic signed [STEP_W-1:0] rsp_shoulder_steps_ff;
   logic signed [STEP_W-1:0] rsp_base_steps_ff;
   logic signed [STEP_W-1:0] rsp_elbow_steps_ff;
   logic                     rsp_shoulder_dir_update_ff;
   logic                     rsp_base_dir_update_ff;
   logic                     rsp_elbow_dir_update_ff;
   logic                     rsp_dir_level_ff;
   logic                     rsp_unreachable_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (flg_p5_ff.unreach) begin
            rsp_shoulder_steps_ff <= '0;
            rsp_base_steps_ff     <= '0;
            rsp_elbow_steps_ff    <= '0;
         end else begin
            rsp_shoulder_steps_ff <= sat_steps(prod_sh_ff, neg_ff[2]);
            rsp_base_steps_ff     <= sat_steps(prod_rot_ff, neg_ff[1]);
            rsp_elbow_steps_ff    <= sat_steps(prod_el_ff, neg_ff[0]);
         end
         rsp_shoulder_dir_update_ff <= nz_ff[2] && !flg_p5_ff.unreach;
         rsp_base_dir_update_ff     <= nz_ff[1] && !flg_p5_ff.unreach;
         rsp_elbow_dir_update_ff    <= nz_ff[0] && !flg_p5_ff.unreach;
         rsp_dir_level_ff           <= !flg_p5_ff.rev;
         rsp_unreachable_ff         <= flg_p5_ff.unreach;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_shoulder_steps      = rsp_shoulder_steps_ff;
   assign rsp_base_steps          = rsp_base_steps_ff;
   assign rsp_elbow_steps         = rsp_elbow_steps_ff;
   assign rsp_shoulder_dir_update = rsp_shoulder_dir_update_ff;
   assign rsp_base_dir_update     = rsp_base_dir_update_ff;
   assign rsp_elbow_dir_update    = rsp_elbow_dir_update_ff;
   assign rsp_dir_level           = rsp_dir_level_ff;
   assign rsp_unreachable         = rsp_unreachable_ff;

   // ---------------------------------------------------------------- checks
   // out of reach: nothing moves
   `AIK_ASSERT_IMP(a_unreach_quiet, clock, reset, rsp_valid_ff && rsp_unreachable_ff, (rsp_shoulder_steps_ff == '0) && (rsp_base_steps_ff == '0) && (rsp_elbow_steps_ff == '0) && !rsp_shoulder_dir_update_ff && !rsp_base_dir_update_ff && !rsp_elbow_dir_update_ff)
   // zero base angle never yields base steps
   `AIK_ASSERT_IMP(a_base_zero, clock, reset, rsp_valid_ff && !rsp_base_dir_update_ff, rsp_base_steps_ff == '0)
   // folded base and shoulder angles stay in their windows
   `AIK_ASSERT_IMP(a_rot_window, clock, reset, v_p2_ff, (rot_f_ff > -(HALF_PI_Q13 + QUARTER_PI_Q13)) && (rot_f_ff <= HALF_PI_Q13))
   `AIK_ASSERT_IMP(a_low_window, clock, reset, v_p2_ff, (low_f_ff > -(HALF_PI_Q13 + QUARTER_PI_Q13)) && (low_f_ff <= QUARTER_PI_Q13))
   // folded elbow angle window
   `AIK_ASSERT_IMP(a_high_window, clock, reset, v_p4_ff, (high_f_ff > -(THIRD_PI_Q13 + SIXTH_PI_Q13)) && (high_f_ff <= THIRD_PI_Q13))

endmodule
`default_nettype wire

[sv/aiks_isqrt.sv]
`default_nettype none
// Pipelined floor square root, one root bit per stage.
module aiks_isqrt (
   input  logic                        clock,
   input  logic                        en,
   input  logic [aiks_pkg::SQ_W-1:0]   radicand,
   output logic [aiks_pkg::ROOT_W-1:0] root
);
   import aiks_pkg::*;

   localparam int REM_W = ROOT_W + 2;

   logic [SQ_W-1:0]   num_ff [0:ROOT_W];
   logic [ROOT_W-1:0] q_ff   [0:ROOT_W];
   logic [REM_W-1:0]  rem_ff [0:ROOT_W];

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff[0] <= radicand;
         q_ff[0]   <= '0;
         rem_ff[0] <= '0;
      end
   end

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic [REM_W-1:0] trial_r;
      logic [REM_W-1:0] trial_t;
      logic             ge;

      assign trial_r = {rem_ff[k][REM_W-3:0], num_ff[k][SQ_W-1 -: 2]};
      assign trial_t = {q_ff[k], 2'b01};
      assign ge      = (trial_r >= trial_t);

      always_ff @(posedge clock) begin
         if (en) begin
            num_ff[k+1] <= num_ff[k] << 2;
            q_ff[k+1]   <= {q_ff[k][ROOT_W-2:0], ge};
            rem_ff[k+1] <= ge ? (trial_r - trial_t) : trial_r;
         end
      end
   end

   assign root = q_ff[ROOT_W];

endmodule
`default_nettype wire

[sv/aiks_cordic.sv]
`default_nettype none
// Pipelined CORDIC vectoring, atan2(y, x) in Q16 radians.
module aiks_cordic (
   input  logic                             clock,
   input  logic                             en,
   input  logic signed [aiks_pkg::CIN_W-1:0] y_in,
   input  logic signed [aiks_pkg::CIN_W-1:0] x_in,
   output logic signed [aiks_pkg::CZ_W-1:0]  angle
);
   import aiks_pkg::*;

   logic signed [CX_W-1:0] x_ff [0:CORDIC_ITERATIONS];
   logic signed [CX_W-1:0] y_ff [0:CORDIC_ITERATIONS];
   logic signed [CZ_W-1:0] z_ff [0:CORDIC_ITERATIONS];

   logic signed [CX_W-1:0] xe;
   logic signed [CX_W-1:0] ye;
   logic signed [CZ_W-1:0] z0;

   // left half plane: rotate by pi first
   always_comb begin
      xe = {{(CX_W-CIN_W){x_in[CIN_W-1]}}, x_in};
      ye = {{(CX_W-CIN_W){y_in[CIN_W-1]}}, y_in};
      z0 = '0;
      if (x_in[CIN_W-1]) begin
         z0 = y_in[CIN_W-1] ? -PI_Q16 : PI_Q16;
         xe = -xe;
         ye = -ye;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= xe <<< PRESCALE_SH;
         y_ff[0] <= ye <<< PRESCALE_SH;
         z_ff[0] <= z0;
      end
   end

   for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_iter
      logic signed [CX_W-1:0] dx;
      logic signed [CX_W-1:0] dy;

      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;

      always_ff @(posedge clock) begin
         if (en) begin
            if (!y_ff[i][CX_W-1]) begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + atan_q16(i);
            end else begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - atan_q16(i);
            end
         end
      end
   end

   assign angle = z_ff[CORDIC_ITERATIONS];

endmodule
`default_nettype wire
